/* hw/rtl/box_intersection_over_union_top_macros.svh */
// assertion macros for the box intersection over union block
`ifndef BOX_INTERSECTION_OVER_UNION_TOP_MACROS_SVH
`define BOX_INTERSECTION_OVER_UNION_TOP_MACROS_SVH

`ifndef SYNTHESIS

// consequent holds in the same cycle as the antecedent
`define BIOU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same cycle check");

// consequent holds in the cycle after the antecedent
`define BIOU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next cycle check");

`else

`define BIOU_ASSERT_SAME(label, clk, rst, ante, cons)
`define BIOU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hw/rtl/biou_pkg.sv */
`timescale 1ns / 1ps

package biou_pkg;

   // side flags that ride along with each item through the divider
   typedef struct packed {
      logic no_overlap;
      logic saturate;
   } biou_flags_type;

endpackage

/* hw/rtl/biou_frac_div.sv */
`timescale 1ns / 1ps

// pipelined restoring divider, one quotient bit per stage
module biou_frac_div #(
   parameter int DEN_BITS  = 27,
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic                    in_valid,
   input  biou_pkg::biou_flags_type in_flags,
   input  logic [DEN_BITS-1:0]     in_num,
   input  logic [DEN_BITS-1:0]     in_den,
   output logic                    out_valid,
   output biou_pkg::biou_flags_type out_flags,
   output logic [FRAC_BITS-1:0]    out_quot
);

   logic                     valid_ff [FRAC_BITS];
   biou_pkg::biou_flags_type flags_ff [FRAC_BITS];
   logic [DEN_BITS-1:0]      rem_ff   [FRAC_BITS];
   logic [DEN_BITS-1:0]      den_ff   [FRAC_BITS];
   logic [FRAC_BITS-1:0]     quot_ff  [FRAC_BITS];

   for (genvar k = 0; k < FRAC_BITS; k++) begin : g_step
      logic                     valid_prev;
      biou_pkg::biou_flags_type flags_prev;
      logic [DEN_BITS-1:0]      rem_prev;
      logic [DEN_BITS-1:0]      den_prev;
      logic [FRAC_BITS-1:0]     quot_prev;
      logic [DEN_BITS:0]        shifted;
      logic                     take;
      logic [DEN_BITS-1:0]      rem_in;
      logic [FRAC_BITS-1:0]     quot_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign flags_prev = in_flags;
         assign rem_prev   = in_num;
         assign den_prev   = in_den;
         assign quot_prev  = '0;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign flags_prev = flags_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign den_prev   = den_ff[k-1];
         assign quot_prev  = quot_ff[k-1];
      end

      // trial subtract of the doubled remainder
      assign shifted = {rem_prev, 1'b0};
      assign take    = shifted >= {1'b0, den_prev};
      assign rem_in  = take ? DEN_BITS'(shifted - {1'b0, den_prev})
                            : shifted[DEN_BITS-1:0];
      assign quot_in = {quot_prev[FRAC_BITS-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            flags_ff[k] <= flags_prev;
            rem_ff[k]   <= rem_in;
            den_ff[k]   <= den_prev;
            quot_ff[k]  <= quot_in;
         end
      end
   end

   assign out_valid = valid_ff[FRAC_BITS-1];
   assign out_flags = flags_ff[FRAC_BITS-1];
   assign out_quot  = quot_ff[FRAC_BITS-1];

endmodule

/* hw/rtl/box_intersection_over_union_top.sv */
`timescale 1ns / 1ps
// box intersection over union
// req_ channel: one item is a pair of axis-aligned boxes, a and b, each given as
// signed left, top, right and bottom pixel edges of COORD_BITS bits
// rsp_ channel: one item per request, iou_ratio as an unsigned fraction with
// FRAC_BITS fractional bits (truncated, 1 << FRAC_BITS is one) and no_overlap,
// set when the boxes do not overlap and the ratio is zero
// inverted boxes whose union is not above the intersection give exactly one
// pipeline: FRAC_BITS + 4 register stages (20 at the defaults): edge min/max, the
// three products, the area sum, the union, then one stage per quotient bit of the
// restoring divider
// throughput: one item per cycle when not stalled; every stage moves on the same enable
// stall: while a result waits with rsp_ready low the whole pipeline holds and
// req_ready drops, so nothing is lost or repeated
// reset: synchronous, active high; clears every valid bit and holds req_ready low,
// the block can take an item as soon as reset is released
`include "box_intersection_over_union_top_macros.svh"

module box_intersection_over_union_top #(
   parameter int COORD_BITS = 13,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_a_left,
   input  logic signed [COORD_BITS-1:0] req_a_top,
   input  logic signed [COORD_BITS-1:0] req_a_right,
   input  logic signed [COORD_BITS-1:0] req_a_bottom,
   input  logic signed [COORD_BITS-1:0] req_b_left,
   input  logic signed [COORD_BITS-1:0] req_b_top,
   input  logic signed [COORD_BITS-1:0] req_b_right,
   input  logic signed [COORD_BITS-1:0] req_b_bottom,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [FRAC_BITS:0]           rsp_iou_ratio,
   output logic                         rsp_no_overlap
);

   // edge differences, products, area sum and divider widths
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   localparam int SUM_BITS   = PROD_BITS + 1;
   localparam int DEN_BITS   = 2 * COORD_BITS + 1;
   localparam int RATIO_BITS = FRAC_BITS + 1;
   localparam logic [RATIO_BITS-1:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   // whole pipeline moves unless a finished result is held back
   logic advance;

   // stage 1: overlap extents and box extents
   logic                        s1_valid_ff;
   logic signed [DIFF_BITS-1:0] ow_ff, oh_ff, aw_ff, ah_ff, bw_ff, bh_ff;
   logic signed [COORD_BITS-1:0] min_r, max_l, min_b, max_t;
   logic signed [DIFF_BITS-1:0]  ow_in, oh_in, aw_in, ah_in, bw_in, bh_in;

   // stage 2: intersection and box areas
   logic                        s2_valid_ff;
   logic                        s2_none_ff;
   logic signed [PROD_BITS-1:0] inter_ff, area_a_ff, area_b_ff;
   logic                        none_in;

   // stage 3: area sum
   logic                        s3_valid_ff;
   logic                        s3_none_ff;
   logic signed [PROD_BITS-1:0] s3_inter_ff;
   logic signed [SUM_BITS-1:0]  sum_ff;

   // stage 4: union and saturation check
   logic                        s4_valid_ff;
   biou_pkg::biou_flags_type    s4_flags_ff;
   logic [DEN_BITS-1:0]         num_ff, den_ff;
   logic signed [SUM_BITS-1:0]  uni_in;
   logic                        sat_in;

   // divider output
   logic                        div_valid;
   biou_pkg::biou_flags_type    div_flags;
   logic [FRAC_BITS-1:0]        div_quot;

   assign advance   = !div_valid || rsp_ready;
   // no item is taken while reset is high
   assign req_ready = advance && !reset;

   // stage 1 logic
   assign min_r = (req_a_right < req_b_right) ? req_a_right : req_b_right;
   assign max_l = (req_a_left > req_b_left) ? req_a_left : req_b_left;
   assign min_b = (req_a_bottom < req_b_bottom) ? req_a_bottom : req_b_bottom;
   assign max_t = (req_a_top > req_b_top) ? req_a_top : req_b_top;
   assign ow_in = DIFF_BITS'(min_r) - DIFF_BITS'(max_l);
   assign oh_in = DIFF_BITS'(min_b) - DIFF_BITS'(max_t);
   assign aw_in = DIFF_BITS'(req_a_right) - DIFF_BITS'(req_a_left);
   assign ah_in = DIFF_BITS'(req_a_bottom) - DIFF_BITS'(req_a_top);
   assign bw_in = DIFF_BITS'(req_b_right) - DIFF_BITS'(req_b_left);
   assign bh_in = DIFF_BITS'(req_b_bottom) - DIFF_BITS'(req_b_top);

   // stage 2 logic: zero or negative extent means no overlap
   assign none_in = ow_ff[DIFF_BITS-1] || (ow_ff == '0)
                 || oh_ff[DIFF_BITS-1] || (oh_ff == '0);

   // stage 4 logic: union not above intersection when sum <= 2 * inter
   assign uni_in = sum_ff - SUM_BITS'(s3_inter_ff);
   assign sat_in = sum_ff <= (SUM_BITS'(s3_inter_ff) <<< 1);

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (advance) begin
         ow_ff                  <= ow_in;
         oh_ff                  <= oh_in;
         aw_ff                  <= aw_in;
         ah_ff                  <= ah_in;
         bw_ff                  <= bw_in;
         bh_ff                  <= bh_in;
         s2_none_ff             <= none_in;
         inter_ff               <= ow_ff * oh_ff;
         area_a_ff              <= aw_ff * ah_ff;
         area_b_ff              <= bw_ff * bh_ff;
         s3_none_ff             <= s2_none_ff;
         s3_inter_ff            <= inter_ff;
         sum_ff                 <= SUM_BITS'(area_a_ff) + SUM_BITS'(area_b_ff);
         s4_flags_ff.no_overlap <= s3_none_ff;
         s4_flags_ff.saturate   <= sat_in;
         num_ff                 <= s3_inter_ff[DEN_BITS-1:0];
         den_ff                 <= uni_in[DEN_BITS-1:0];
      end
   end

   // one quotient bit per stage
   biou_frac_div #(
      .DEN_BITS  (DEN_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s4_valid_ff),
      .in_flags  (s4_flags_ff),
      .in_num    (num_ff),
      .in_den    (den_ff),
      .out_valid (div_valid),
      .out_flags (div_flags),
      .out_quot  (div_quot)
   );

   // result select: no overlap wins over saturation
   assign rsp_valid      = div_valid;
   assign rsp_no_overlap = div_flags.no_overlap;
   assign rsp_iou_ratio  = div_flags.no_overlap ? '0
                         : div_flags.saturate   ? RATIO_ONE
                         : {1'b0, div_quot};

   `BIOU_ASSERT_SAME(a_none_zero, clock, reset, rsp_valid && rsp_no_overlap, rsp_iou_ratio == '0)
   `BIOU_ASSERT_SAME(a_ratio_max, clock, reset, rsp_valid, rsp_iou_ratio <= RATIO_ONE)
   `BIOU_ASSERT_SAME(a_stall_block, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   `BIOU_ASSERT_NEXT(a_hold_s4, clock, reset, !advance && s4_valid_ff, s4_valid_ff)

endmodule
